[rtl/irdf_pkg.sv]
package irdf_pkg;

    localparam int ByteW  = 8;
    localparam int KindW  = 2;
    localparam int CountW = 9;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    // transparency mask applied to the byte after an escape
    localparam logic [ByteW-1:0] XOR_MASK = 8'h20;

    // event codes
    localparam logic [KindW-1:0] EV_DATA  = 2'd0;
    localparam logic [KindW-1:0] EV_START = 2'd1;
    localparam logic [KindW-1:0] EV_END   = 2'd2;
    localparam logic [KindW-1:0] EV_ABORT = 2'd3;

    // register indexes (word address)
    localparam logic [1:0] REG_BEGIN  = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_ESCAPE = 2'd2;

    // register reset values
    localparam logic [ByteW-1:0] BEGIN_RST  = 8'hC0;
    localparam logic [ByteW-1:0] END_RST    = 8'hC1;
    localparam logic [ByteW-1:0] ESCAPE_RST = 8'h7D;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BOF  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ByteW-1:0] begin_flag;
        logic [ByteW-1:0] end_flag;
        logic [ByteW-1:0] escape;
    } cfg_t;

    typedef struct packed {
        logic [ByteW-1:0]  frame_byte;
        logic [KindW-1:0]  event_kind;
        logic [CountW-1:0] frame_length;
        logic              overflow;
    } result_t;

endpackage

[rtl/irlap_async_frame_deframer.sv]
// results are registered: output register first, skid register while it waits
// throughput: one received byte per cycle; the two-entry output stage (output register plus
//   skid register) keeps intake going while one result waits, and only a full skid entry holds
//   in_ready low
// reset (rst_n, async, active low): receive machine idle, count and overflow cleared,
//   flag registers back to 0xC0 / 0xC1 / 0x7D, output stage empty
module irlap_async_frame_deframer
    import irdf_pkg::*;
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic              clk,
    input  logic              rst_n,

    // apb-style register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,

    // received byte channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ByteW-1:0]  rx_byte,

    // frame event channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ByteW-1:0]  frame_byte,
    output logic [KindW-1:0]  event_kind,
    output logic [CountW-1:0] frame_length,
    output logic              overflow
);

    // length limit, capped so the count still fits its 9 bits
    localparam int CapInt = (MAX_FRAME < 511) ? MAX_FRAME : 511;
    localparam logic [CountW-1:0] LenCap = CountW'(CapInt);

    cfg_t    cfg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    can_take;

    // an item is taken whenever the skid register is free
    assign in_ready = can_take;
    assign accept   = in_valid & can_take;

    // flag and escape byte registers
    irdf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // receive machine: unstuffing, counting and event decode in one pass
    irdf_core #(
        .LEN_CAP (LenCap)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register with skid entry; bytes that make no event are never loaded
    irdf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept & res_valid),
        .load_data (res),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign frame_byte   = out_data.frame_byte;
    assign event_kind   = out_data.event_kind;
    assign frame_length = out_data.frame_length;
    assign overflow     = out_data.overflow;

endmodule

[rtl/irdf_regs.sv]
module irdf_regs
    import irdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_BEGIN:  cfg_next.begin_flag = pwdata[ByteW-1:0];
                REG_END:    cfg_next.end_flag   = pwdata[ByteW-1:0];
                REG_ESCAPE: cfg_next.escape     = pwdata[ByteW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BEGIN:  prdata = {{(DataW-ByteW){1'b0}}, cfg_reg.begin_flag};
            REG_END:    prdata = {{(DataW-ByteW){1'b0}}, cfg_reg.end_flag};
            REG_ESCAPE: prdata = {{(DataW-ByteW){1'b0}}, cfg_reg.escape};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_flag <= BEGIN_RST;
            cfg_reg.end_flag   <= END_RST;
            cfg_reg.escape     <= ESCAPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/irdf_core.sv]
module irdf_core
    import irdf_pkg::*;
#(
    parameter logic [CountW-1:0] LEN_CAP = 9'd256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [ByteW-1:0] rx_byte,
    input  cfg_t             cfg,
    output logic             res_valid,
    output result_t          res
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              is_bof;
    logic              is_eof;
    logic              is_esc;
    logic              room;
    logic [ByteW-1:0]  out_byte;
    logic [KindW-1:0]  out_kind;

    assign is_bof = (rx_byte == cfg.begin_flag);
    assign is_eof = (rx_byte == cfg.end_flag);
    assign is_esc = (rx_byte == cfg.escape);
    assign room   = (count_reg < LEN_CAP);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;
        out_byte   = rx_byte;
        out_kind   = EV_DATA;
        case (phase_reg)
            PH_IDLE:
            begin
                if (is_bof)
                begin
                    phase_next = PH_BOF;
                    count_next = CountW'(1);
                    ovf_next   = 1'b0;
                    res_valid  = 1'b1;
                    out_kind   = EV_START;
                end
            end
            PH_BOF, PH_ESC:
            begin
                if (is_bof)
                begin
                    phase_next = PH_BOF;
                    count_next = CountW'(1);
                    ovf_next   = 1'b0;
                    res_valid  = 1'b1;
                    out_kind   = EV_START;
                end
                else if (is_esc && (phase_reg == PH_BOF))
                begin
                    phase_next = PH_ESC;
                end
                else if (is_eof)
                begin
                    // abort reports the count before the end flag
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    out_kind   = EV_ABORT;
                end
                else
                begin
                    phase_next = PH_DATA;
                    if (phase_reg == PH_ESC)
                    begin
                        out_byte = rx_byte ^ XOR_MASK;
                    end
                    if (room)
                    begin
                        count_next = count_reg + CountW'(1);
                        res_valid  = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                if (is_esc)
                begin
                    phase_next = PH_ESC;
                end
                else if (is_bof)
                begin
                    phase_next = PH_BOF;
                    count_next = CountW'(1);
                    ovf_next   = 1'b0;
                    res_valid  = 1'b1;
                    out_kind   = EV_START;
                end
                else if (is_eof)
                begin
                    // end flag is counted when there is room, frame ends anyway
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    out_kind   = EV_END;
                    if (room)
                    begin
                        count_next = count_reg + CountW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    if (room)
                    begin
                        count_next = count_reg + CountW'(1);
                        res_valid  = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res.frame_byte   = out_byte;
    assign res.event_kind   = out_kind;
    assign res.frame_length = count_next;
    assign res.overflow     = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[rtl/irdf_outbuf.sv]
module irdf_outbuf
    import irdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    drain;

    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign drain     = main_valid_reg & out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no new item while the skid stage is full
            if (drain)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = load_data;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_data_next  = load_data;
            end
        end
        else if (drain)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
